// ===== rtl/gsvst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsvst_pkg
// Shared codes and character constants of the GSV satellite table core.
// ----------------------------------------------------------------------------
package gsvst_pkg;

   localparam logic [1:0] FUNC_BYTE  = 2'd0;
   localparam logic [1:0] FUNC_SWEEP = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [1:0] REG_MAX_AGE = 2'd0;
   localparam logic [1:0] REG_SNR_THR = 2'd1;
   localparam logic [1:0] REG_MIN_LEN = 2'd2;

   localparam logic [1:0] SYS_GPS     = 2'd0;
   localparam logic [1:0] SYS_BDS     = 2'd1;
   localparam logic [1:0] SYS_GLONASS = 2'd2;
   localparam logic [1:0] SYS_OTHER   = 2'd3;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_G      = 8'h47;
   localparam logic [7:0] CH_S      = 8'h53;
   localparam logic [7:0] CH_V      = 8'h56;
   localparam logic [7:0] CH_P      = 8'h50;
   localparam logic [7:0] CH_B      = 8'h42;
   localparam logic [7:0] CH_D      = 8'h44;
   localparam logic [7:0] CH_L      = 8'h4C;

   localparam logic [9:0]  FIELD_MAX     = 10'd999;
   localparam logic [15:0] MAX_AGE_RESET = 16'd5000;
   localparam logic [9:0]  SNR_THR_RESET = 10'd15;
   localparam logic [6:0]  MIN_LEN_RESET = 7'd10;

   typedef logic [41:0] info_type;

endpackage
`default_nettype wire

// ===== rtl/gsv_satellite_table_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsv_satellite_table_core
// Parses NMEA GSV sentences into a satellite table with ageing and counting.
// ----------------------------------------------------------------------------
// Usage: one request beat carries func, byte_value, time_ms, entry_index and
// system_select; every request yields exactly one response beat with the
// table count, tracked counts, the selected in-view count and the read entry.
// A request is taken only when the core is idle and the response register is
// empty, so the core works on one beat at a time.
// An ordinary byte, a no-op or a read outside the table is answered from the
// execute state; a read that hits adds a table read. A CR or LF that ends a
// valid GSV sentence steps through each group and searches the table entries
// for a match in its read and compare states. A sweep reads and checks each
// entry, moves the last entry into a removed one's place, then reads and counts
// every kept entry, one entry at a time, set by the single read port.
// Configuration beats on the csr_ channel are always accepted and must be
// written only while the core is idle.
// Reset clears the count, the line parser and the counters; table memory is
// not cleared since only entries below the count are ever used. When the
// receiver stalls, the response is held and no new request is accepted.
// ----------------------------------------------------------------------------
module gsv_satellite_table_core
   import gsvst_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int LINE_LIMIT  = 128,
   parameter int MAX_TOKENS  = 20
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic [31:0] req_time_ms,
   input  wire logic [5:0]  req_entry_index,
   input  wire logic [1:0]  req_system_select,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [6:0]       rsp_entry_count,
   output logic [6:0]       rsp_tracked_gps,
   output logic [6:0]       rsp_tracked_bds,
   output logic [6:0]       rsp_tracked_glonass,
   output logic [6:0]       rsp_tracked_other,
   output logic [9:0]       rsp_in_view,
   output logic             rsp_entry_valid,
   output logic [1:0]       rsp_entry_system,
   output logic [9:0]       rsp_entry_prn,
   output logic [9:0]       rsp_entry_elevation,
   output logic [9:0]       rsp_entry_azimuth,
   output logic [9:0]       rsp_entry_snr,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int AW     = $clog2(TABLE_DEPTH);
   localparam int CW     = $clog2(TABLE_DEPTH + 1);
   localparam int PW     = $clog2(LINE_LIMIT);
   localparam int TW     = $clog2(MAX_TOKENS);
   localparam int GS     = (MAX_TOKENS - 4) / 4;
   localparam int NSLOT  = 4 * GS;
   localparam int GW     = $clog2(GS + 1);
   localparam int SW     = $clog2(NSLOT);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_EXEC   = 4'd1;
   localparam logic [3:0] ST_GROUP  = 4'd2;
   localparam logic [3:0] ST_SRD    = 4'd3;
   localparam logic [3:0] ST_SCMP   = 4'd4;
   localparam logic [3:0] ST_SWRD   = 4'd5;
   localparam logic [3:0] ST_SWCHK  = 4'd6;
   localparam logic [3:0] ST_SWMV   = 4'd7;
   localparam logic [3:0] ST_CTRD   = 4'd8;
   localparam logic [3:0] ST_CTCHK  = 4'd9;
   localparam logic [3:0] ST_READ   = 4'd10;

   info_type    info_mem [TABLE_DEPTH];
   logic [31:0] time_mem [TABLE_DEPTH];
   info_type    info_rd_ff;
   logic [31:0] time_rd_ff;
   logic [AW-1:0] raddr;
   logic          mem_we;
   logic [AW-1:0] waddr;
   info_type      wdata_info;
   logic [31:0]   wdata_time;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  func_ff;
   logic [7:0]  byte_ff;
   logic [31:0] now_ff;
   logic [5:0]  idx_ff;
   logic [1:0]  sel_ff;

   logic [15:0] max_age_ff;
   logic [9:0]  snr_thr_ff;
   logic [6:0]  min_len_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [GW-1:0] grp_ff, grp_in;
   logic [1:0]    sys_ff, sys_in;
   logic [9:0]    in_view_ff [4];
   logic [9:0]    in_view_in [4];
   logic [CW-1:0] tracked_ff [4];
   logic [CW-1:0] tracked_in [4];

   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    hdr_ff [5];
   logic [7:0]    hdr_in [5];
   logic [TW-1:0] tok_ff, tok_in;
   logic [9:0]    acc_ff, acc_in;
   logic          dopen_ff, dopen_in;
   logic          star_ff, star_in;
   logic [9:0]    pg_ff [NSLOT];
   logic [9:0]    pg_in [NSLOT];
   logic [9:0]    piv_ff, piv_in;

   logic          rsp_valid_ff;
   logic          fin;
   logic          fin_ent;
   logic          line_clr;

   logic [13:0]   acc_wide;
   logic [9:0]    acc_sat;
   logic [9:0]    g_prn, g_ele, g_azi, g_snr;
   logic [1:0]    talker;
   logic [31:0]   age;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   assign acc_wide = 14'(acc_ff) * 14'd10 + 14'(byte_ff - CH_ZERO);
   assign acc_sat  = (acc_wide > 14'(FIELD_MAX)) ? FIELD_MAX : acc_wide[9:0];
   assign g_prn    = pg_ff[SW'(4 * grp_ff)];
   assign g_ele    = pg_ff[SW'(4 * grp_ff + 1)];
   assign g_azi    = pg_ff[SW'(4 * grp_ff + 2)];
   assign g_snr    = pg_ff[SW'(4 * grp_ff + 3)];
   assign age      = now_ff - time_rd_ff;

   always_comb begin
      if (hdr_ff[0] == CH_G && hdr_ff[1] == CH_P) begin
         talker = SYS_GPS;
      end else if ((hdr_ff[0] == CH_B && hdr_ff[1] == CH_D) ||
                   (hdr_ff[0] == CH_G && hdr_ff[1] == CH_B)) begin
         talker = SYS_BDS;
      end else if (hdr_ff[0] == CH_G && hdr_ff[1] == CH_L) begin
         talker = SYS_GLONASS;
      end else begin
         talker = SYS_OTHER;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cnt_in     = cnt_ff;
      grp_in     = grp_ff;
      sys_in     = sys_ff;
      in_view_in = in_view_ff;
      tracked_in = tracked_ff;
      pos_in     = pos_ff;
      hdr_in     = hdr_ff;
      tok_in     = tok_ff;
      acc_in     = acc_ff;
      dopen_in   = dopen_ff;
      star_in    = star_ff;
      pg_in      = pg_ff;
      piv_in     = piv_ff;
      raddr      = cnt_ff[AW-1:0];
      mem_we     = 1'b0;
      waddr      = cnt_ff[AW-1:0];
      wdata_info = {sys_ff, g_prn, g_ele, g_azi, g_snr};
      wdata_time = now_ff;
      fin        = 1'b0;
      fin_ent    = 1'b0;
      line_clr   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (func_ff)
               FUNC_BYTE: begin
                  if (byte_ff == CH_DOLLAR) begin
                     line_clr = 1'b1;
                     fin      = 1'b1;
                     state_in = ST_IDLE;
                  end else if (byte_ff == CH_LF || byte_ff == CH_CR) begin
                     if (pos_ff >= PW'(6) && 8'(pos_ff) > 8'(min_len_ff) &&
                         hdr_ff[2] == CH_G && hdr_ff[3] == CH_S &&
                         hdr_ff[4] == CH_V && tok_ff >= TW'(3)) begin
                        in_view_in[talker] = piv_ff;
                        sys_in   = talker;
                        grp_in   = '0;
                        state_in = ST_GROUP;
                     end else begin
                        line_clr = 1'b1;
                        fin      = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     fin      = 1'b1;
                     state_in = ST_IDLE;
                     if (9'(pos_ff) < 9'(LINE_LIMIT - 1)) begin
                        if (pos_ff >= PW'(1) && pos_ff <= PW'(5)) begin
                           hdr_in[3'(pos_ff - PW'(1))] = byte_ff;
                        end
                        pos_in = pos_ff + PW'(1);
                        if ((byte_ff == CH_COMMA || byte_ff == CH_STAR) && !star_ff) begin
                           if (6'(tok_ff) < 6'(MAX_TOKENS - 1)) begin
                              tok_in   = tok_ff + TW'(1);
                              acc_in   = '0;
                              dopen_in = 1'b1;
                              if (tok_in == TW'(3)) begin
                                 piv_in = '0;
                              end
                              for (int k = 0; k < NSLOT; k++) begin
                                 if (6'(tok_in) == 6'(k + 4)) begin
                                    pg_in[k] = '0;
                                 end
                              end
                              if (byte_ff == CH_STAR) begin
                                 star_in = 1'b1;
                              end
                           end else begin
                              dopen_in = 1'b0;
                           end
                        end else if (byte_ff >= CH_ZERO && byte_ff <= CH_NINE && dopen_ff) begin
                           acc_in = acc_sat;
                           if (tok_ff == TW'(3)) begin
                              piv_in = acc_sat;
                           end
                           for (int k = 0; k < NSLOT; k++) begin
                              if (6'(tok_ff) == 6'(k + 4)) begin
                                 pg_in[k] = acc_sat;
                              end
                           end
                        end else begin
                           dopen_in = 1'b0;
                        end
                     end
                  end
               end
               FUNC_SWEEP: begin
                  cnt_in   = '0;
                  state_in = ST_SWRD;
               end
               FUNC_READ: begin
                  raddr = idx_ff[AW-1:0];
                  if (9'(idx_ff) < 9'(count_ff)) begin
                     state_in = ST_READ;
                  end else begin
                     fin      = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  fin      = 1'b1;
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_GROUP: begin
            cnt_in = '0;
            if (32'(grp_ff) >= 32'(GS) || 8'(7 + 4 * grp_ff) > 8'(tok_ff)) begin
               line_clr = 1'b1;
               fin      = 1'b1;
               state_in = ST_IDLE;
            end else if (g_prn == '0) begin
               grp_in = grp_ff + GW'(1);
            end else if (count_ff == '0) begin
               mem_we   = 1'b1;
               waddr    = '0;
               count_in = CW'(1);
               grp_in   = grp_ff + GW'(1);
            end else begin
               state_in = ST_SRD;
            end
         end
         ST_SRD: begin
            raddr    = cnt_ff[AW-1:0];
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            if (info_rd_ff[41:40] == sys_ff && info_rd_ff[39:30] == g_prn) begin
               mem_we   = 1'b1;
               waddr    = cnt_ff[AW-1:0];
               grp_in   = grp_ff + GW'(1);
               state_in = ST_GROUP;
            end else if (cnt_ff + CW'(1) < count_ff) begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = ST_SRD;
            end else begin
               if (32'(count_ff) < 32'(TABLE_DEPTH)) begin
                  mem_we   = 1'b1;
                  waddr    = count_ff[AW-1:0];
                  count_in = count_ff + CW'(1);
               end
               grp_in   = grp_ff + GW'(1);
               state_in = ST_GROUP;
            end
         end
         ST_SWRD: begin
            raddr = cnt_ff[AW-1:0];
            if (cnt_ff < count_ff) begin
               state_in = ST_SWCHK;
            end else begin
               cnt_in     = '0;
               tracked_in = '{default: '0};
               state_in   = ST_CTRD;
            end
         end
         ST_SWCHK: begin
            raddr = AW'(count_ff - CW'(1));
            if (age > 32'(max_age_ff)) begin
               state_in = ST_SWMV;
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = ST_SWRD;
            end
         end
         ST_SWMV: begin
            mem_we     = 1'b1;
            waddr      = cnt_ff[AW-1:0];
            wdata_info = info_rd_ff;
            wdata_time = time_rd_ff;
            count_in   = count_ff - CW'(1);
            state_in   = ST_SWRD;
         end
         ST_CTRD: begin
            raddr = cnt_ff[AW-1:0];
            if (cnt_ff < count_ff) begin
               state_in = ST_CTCHK;
            end else begin
               fin      = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CTCHK: begin
            if (info_rd_ff[9:0] > snr_thr_ff) begin
               tracked_in[info_rd_ff[41:40]] = tracked_ff[info_rd_ff[41:40]] + CW'(1);
            end
            cnt_in   = cnt_ff + CW'(1);
            state_in = ST_CTRD;
         end
         ST_READ: begin
            fin      = 1'b1;
            fin_ent  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (line_clr) begin
         pos_in   = (func_ff == FUNC_BYTE && byte_ff == CH_DOLLAR) ? PW'(1) : '0;
         dopen_in = !(func_ff == FUNC_BYTE && byte_ff == CH_DOLLAR);
         hdr_in   = '{default: '0};
         tok_in   = '0;
         acc_in   = '0;
         star_in  = 1'b0;
         pg_in    = '{default: '0};
         piv_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         info_mem[waddr] <= wdata_info;
         time_mem[waddr] <= wdata_time;
      end
      info_rd_ff <= info_mem[raddr];
      time_rd_ff <= time_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff <= req_func;
         byte_ff <= req_byte_value;
         now_ff  <= req_time_ms;
         idx_ff  <= req_entry_index;
         sel_ff  <= req_system_select;
      end
      if (fin) begin
         rsp_entry_count     <= 7'(count_ff);
         rsp_tracked_gps     <= 7'(tracked_ff[SYS_GPS]);
         rsp_tracked_bds     <= 7'(tracked_ff[SYS_BDS]);
         rsp_tracked_glonass <= 7'(tracked_ff[SYS_GLONASS]);
         rsp_tracked_other   <= 7'(tracked_ff[SYS_OTHER]);
         rsp_in_view         <= in_view_in[sel_ff];
         rsp_entry_valid     <= fin_ent;
         rsp_entry_system    <= fin_ent ? info_rd_ff[41:40] : 2'd0;
         rsp_entry_prn       <= fin_ent ? info_rd_ff[39:30] : 10'd0;
         rsp_entry_elevation <= fin_ent ? info_rd_ff[29:20] : 10'd0;
         rsp_entry_azimuth   <= fin_ent ? info_rd_ff[19:10] : 10'd0;
         rsp_entry_snr       <= fin_ent ? info_rd_ff[9:0] : 10'd0;
      end
      if (state_ff == ST_GROUP || state_ff == ST_SCMP) begin
         grp_ff <= grp_in;
         sys_ff <= sys_in;
      end else if (state_ff == ST_EXEC) begin
         grp_ff <= grp_in;
         sys_ff <= sys_in;
      end
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         in_view_ff   <= '{default: '0};
         tracked_ff   <= '{default: '0};
         pos_ff       <= '0;
         hdr_ff       <= '{default: '0};
         tok_ff       <= '0;
         acc_ff       <= '0;
         dopen_ff     <= 1'b1;
         star_ff      <= 1'b0;
         pg_ff        <= '{default: '0};
         piv_ff       <= '0;
         max_age_ff   <= MAX_AGE_RESET;
         snr_thr_ff   <= SNR_THR_RESET;
         min_len_ff   <= MIN_LEN_RESET;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         in_view_ff <= in_view_in;
         tracked_ff <= tracked_in;
         pos_ff     <= pos_in;
         hdr_ff     <= hdr_in;
         tok_ff     <= tok_in;
         acc_ff     <= acc_in;
         dopen_ff   <= dopen_in;
         star_ff    <= star_in;
         pg_ff      <= pg_in;
         piv_ff     <= piv_in;
         if (fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MAX_AGE: max_age_ff <= csr_data;
               REG_SNR_THR: snr_thr_ff <= csr_data[9:0];
               REG_MIN_LEN: min_len_ff <= csr_data[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(TABLE_DEPTH))
      else $error("table count exceeds depth");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_we)
      else $error("table write while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_EXEC)
      else $error("accepted beat not executed");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> 9'(idx_ff) < 9'(count_ff))
      else $error("entry read beyond table count");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives NMEA bytes, sweeps, table reads, no-ops and register writes into the
// GSV satellite table core and checks every response against a behavioral model.
// ----------------------------------------------------------------------------
module testbench;
   import gsvst_pkg::*;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  byte_value;
      logic [31:0] time_ms;
      logic [5:0]  entry_index;
      logic [1:0]  system_select;
   } request_type;

   typedef struct packed {
      logic [6:0] entry_count;
      logic [6:0] tracked_gps;
      logic [6:0] tracked_bds;
      logic [6:0] tracked_glonass;
      logic [6:0] tracked_other;
      logic [9:0] in_view;
      logic       entry_valid;
      logic [1:0] entry_system;
      logic [9:0] entry_prn;
      logic [9:0] entry_elevation;
      logic [9:0] entry_azimuth;
      logic [9:0] entry_snr;
   } response_type;

   typedef struct {
      logic [1:0] sys;
      logic [9:0] prn, ele, azi, snr;
   } sat_type;

   localparam int DEPTH = 64;
   localparam int LINE_MAX = 128;
   localparam int TOKEN_MAX = 20;
   localparam int GROUPS = (TOKEN_MAX - 4) / 4;
   localparam int IDLE_LIMIT = 20000;
   localparam logic [1:0] FUNC_NOP = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_func = '0;
   logic [7:0] req_byte_value = '0;
   logic [31:0] req_time_ms = '0;
   logic [5:0] req_entry_index = '0;
   logic [1:0] req_system_select = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   response_type rsp;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   gsv_satellite_table_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_func(req_func), .req_byte_value(req_byte_value),
      .req_time_ms(req_time_ms), .req_entry_index(req_entry_index),
      .req_system_select(req_system_select),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_entry_count(rsp.entry_count), .rsp_tracked_gps(rsp.tracked_gps),
      .rsp_tracked_bds(rsp.tracked_bds), .rsp_tracked_glonass(rsp.tracked_glonass),
      .rsp_tracked_other(rsp.tracked_other), .rsp_in_view(rsp.in_view),
      .rsp_entry_valid(rsp.entry_valid), .rsp_entry_system(rsp.entry_system),
      .rsp_entry_prn(rsp.entry_prn), .rsp_entry_elevation(rsp.entry_elevation),
      .rsp_entry_azimuth(rsp.entry_azimuth), .rsp_entry_snr(rsp.entry_snr),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Table model state.
   logic [15:0] max_age;
   logic [9:0]  snr_limit;
   logic [6:0]  min_len;
   sat_type     sat_table[DEPTH];
   logic [31:0] seen_at[DEPTH];
   int          sat_count;
   logic [9:0]  view_count[4];
   int          tracked[4];
   int          line_pos;
   logic [7:0]  head[5];
   int          tokens;
   int          accum;
   bit          digits_on;
   bit          star_on;
   logic [9:0]  group_val[GROUPS][4];
   logic [9:0]  view_pending;

   request_type  pending_items[$];
   response_type expected_rsp[$];
   int   errors = 0;
   int   accepted = 0;
   int   checked = 0;
   int   sweeps_done = 0;
   int   reads_hit = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   bit   hold_on = 1'b0;
   logic [31:0] clock_ms = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %0s: got %0d expected %0d (response %0d)", what, got, want, checked);
      errors++;
   endtask

   function automatic void clear_line();
      line_pos = 0;
      foreach (head[i]) head[i] = '0;
      tokens = 0;
      accum = 0;
      digits_on = 1'b1;
      star_on = 1'b0;
      foreach (group_val[g, f]) group_val[g][f] = '0;
      view_pending = '0;
   endfunction

   function automatic void put_field(input int tok, input logic [9:0] v);
      if (tok == 3) view_pending = v;
      else if (tok >= 4 && tok < 4 + 4 * GROUPS) group_val[(tok - 4) / 4][(tok - 4) % 4] = v;
   endfunction

   function automatic void place_sat(input logic [1:0] sys, input int g, input logic [31:0] now);
      int slot;
      slot = DEPTH;
      for (int j = 0; j < sat_count; j++) begin
         if (sat_table[j].sys == sys && sat_table[j].prn == group_val[g][0]) begin
            slot = j;
            break;
         end
      end
      if (slot == DEPTH && sat_count < DEPTH) begin
         slot = sat_count;
         sat_count++;
      end
      if (slot < DEPTH) begin
         sat_table[slot].sys = sys;
         sat_table[slot].prn = group_val[g][0];
         sat_table[slot].ele = group_val[g][1];
         sat_table[slot].azi = group_val[g][2];
         sat_table[slot].snr = group_val[g][3];
         seen_at[slot] = now;
      end
   endfunction

   function automatic void close_sentence(input logic [31:0] now);
      logic [1:0] sys;
      sys = SYS_OTHER;
      if (line_pos < 6 || line_pos <= min_len) return;
      if (head[2] != CH_G || head[3] != CH_S || head[4] != CH_V) return;
      if (head[0] == CH_G && head[1] == CH_P) sys = SYS_GPS;
      else if (head[0] == CH_B && head[1] == CH_D) sys = SYS_BDS;
      else if (head[0] == CH_G && head[1] == CH_B) sys = SYS_BDS;
      else if (head[0] == CH_G && head[1] == CH_L) sys = SYS_GLONASS;
      if (tokens < 3) return;
      view_count[sys] = view_pending;
      for (int g = 0; g < GROUPS; g++) begin
         if (7 + 4 * g > tokens) break;
         if (group_val[g][0] != 0) place_sat(sys, g, now);
      end
   endfunction

   function automatic void parse_char(input logic [7:0] c, input logic [31:0] now);
      if (c == CH_DOLLAR) begin
         clear_line();
         line_pos = 1;
         digits_on = 1'b0;
         return;
      end
      if (c == CH_LF || c == CH_CR) begin
         close_sentence(now);
         clear_line();
         return;
      end
      if (line_pos >= LINE_MAX - 1) return;
      if (line_pos >= 1 && line_pos <= 5) head[line_pos - 1] = c;
      line_pos++;
      if ((c == CH_COMMA || c == CH_STAR) && !star_on) begin
         if (tokens < TOKEN_MAX - 1) begin
            tokens++;
            accum = 0;
            digits_on = 1'b1;
            put_field(tokens, '0);
            if (c == CH_STAR) star_on = 1'b1;
         end else begin
            digits_on = 1'b0;
         end
      end else if (c >= CH_ZERO && c <= CH_NINE && digits_on) begin
         accum = accum * 10 + (c - CH_ZERO);
         if (accum > FIELD_MAX) accum = FIELD_MAX;
         put_field(tokens, accum[9:0]);
      end else begin
         digits_on = 1'b0;
      end
   endfunction

   function automatic void age_and_count(input logic [31:0] now);
      int i;
      logic [31:0] age;
      i = 0;
      while (i < sat_count) begin
         age = now - seen_at[i];
         if (age > {16'd0, max_age}) begin
            sat_table[i] = sat_table[sat_count - 1];
            seen_at[i] = seen_at[sat_count - 1];
            sat_count--;
         end else begin
            i++;
         end
      end
      foreach (tracked[k]) tracked[k] = 0;
      for (i = 0; i < sat_count; i++)
         if (sat_table[i].snr > snr_limit) tracked[sat_table[i].sys]++;
   endfunction

   function automatic response_type table_step(input request_type r);
      response_type e;
      if (r.func == FUNC_BYTE) parse_char(r.byte_value, r.time_ms);
      else if (r.func == FUNC_SWEEP) age_and_count(r.time_ms);
      e = '0;
      e.entry_count = sat_count[6:0];
      e.tracked_gps = tracked[0][6:0];
      e.tracked_bds = tracked[1][6:0];
      e.tracked_glonass = tracked[2][6:0];
      e.tracked_other = tracked[3][6:0];
      e.in_view = view_count[r.system_select];
      if (r.func == FUNC_READ && r.entry_index < sat_count) begin
         e.entry_valid = 1'b1;
         e.entry_system = sat_table[r.entry_index].sys;
         e.entry_prn = sat_table[r.entry_index].prn;
         e.entry_elevation = sat_table[r.entry_index].ele;
         e.entry_azimuth = sat_table[r.entry_index].azi;
         e.entry_snr = sat_table[r.entry_index].snr;
      end
      return e;
   endfunction

   // Driver: presents queued items, holding each until the beat is taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_rsp.push_back(table_step({req_func, req_byte_value, req_time_ms,
                                               req_entry_index, req_system_select}));
            accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               request_type r;
               r = pending_items.pop_front();
               req_valid <= 1'b1;
               {req_func, req_byte_value, req_time_ms, req_entry_index,
                req_system_select} <= r;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor and receiver back-pressure.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("unexpected response beat");
               errors++;
            end else begin
               response_type e;
               e = expected_rsp.pop_front();
               if (rsp.entry_count !== e.entry_count)
                  report("entry_count", rsp.entry_count, e.entry_count);
               if (rsp.tracked_gps !== e.tracked_gps)
                  report("tracked_gps", rsp.tracked_gps, e.tracked_gps);
               if (rsp.tracked_bds !== e.tracked_bds)
                  report("tracked_bds", rsp.tracked_bds, e.tracked_bds);
               if (rsp.tracked_glonass !== e.tracked_glonass)
                  report("tracked_glonass", rsp.tracked_glonass, e.tracked_glonass);
               if (rsp.tracked_other !== e.tracked_other)
                  report("tracked_other", rsp.tracked_other, e.tracked_other);
               if (rsp.in_view !== e.in_view) report("in_view", rsp.in_view, e.in_view);
               if (rsp.entry_valid !== e.entry_valid)
                  report("entry_valid", rsp.entry_valid, e.entry_valid);
               if (rsp.entry_system !== e.entry_system)
                  report("entry_system", rsp.entry_system, e.entry_system);
               if (rsp.entry_prn !== e.entry_prn)
                  report("entry_prn", rsp.entry_prn, e.entry_prn);
               if (rsp.entry_elevation !== e.entry_elevation)
                  report("entry_elevation", rsp.entry_elevation, e.entry_elevation);
               if (rsp.entry_azimuth !== e.entry_azimuth)
                  report("entry_azimuth", rsp.entry_azimuth, e.entry_azimuth);
               if (rsp.entry_snr !== e.entry_snr)
                  report("entry_snr", rsp.entry_snr, e.entry_snr);
               if (e.entry_valid) reads_hit++;
               checked++;
            end
         end
         if (hold_on) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   int quiet = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= IDLE_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet);
         $display("testbench: errors");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic push(input logic [1:0] f, input logic [7:0] b, input logic [5:0] idx,
                       input logic [1:0] sel);
      request_type r;
      r.func = f;
      r.byte_value = b;
      r.time_ms = clock_ms;
      r.entry_index = idx;
      r.system_select = sel;
      pending_items.push_back(r);
   endtask

   task automatic push_text(input string s);
      foreach (s[i]) push(FUNC_BYTE, s[i], 6'($urandom), 2'($urandom));
   endtask

   function automatic string talker_pick();
      case ($urandom_range(5))
         0: return "GP";
         1: return "BD";
         2: return "GB";
         3: return "GL";
         4: return "GA";
         default: return "QZ";
      endcase
   endfunction

   function automatic string field_text();
      case ($urandom_range(9))
         0: return "";
         1: return $sformatf("%0d", $urandom_range(99999));
         2: return $sformatf("%0dx7", $urandom_range(50));
         default: return $sformatf("%0d", $urandom_range(99));
      endcase
   endfunction

   // One GSV sentence with random content; broken ones now and then.
   task automatic push_sentence(input int prn_span);
      string s;
      int groups;
      groups = $urandom_range(5);
      s = {"$", talker_pick(), ($urandom_range(19) == 0) ? "GSA" : "GSV", ",3,1,",
           field_text()};
      for (int g = 0; g < groups; g++)
         s = {s, $sformatf(",%0d", $urandom_range(prn_span)), ",", field_text(), ",",
              field_text(), ",", field_text()};
      if ($urandom_range(9) == 0)
         for (int k = 0; k < 12; k++) s = {s, ",1,2"};
      s = {s, "*", $sformatf("%02x", $urandom_range(255))};
      if ($urandom_range(15) == 0) s = s.substr(0, $urandom_range(s.len() - 1));
      push_text(s);
      push(FUNC_BYTE, ($urandom_range(1) == 0) ? CH_CR : CH_LF, 6'($urandom), 2'($urandom));
      clock_ms = clock_ms + $urandom_range(400);
   endtask

   task automatic push_random(input int count, input int prn_span);
      int n;
      n = 0;
      while (n < count) begin
         case ($urandom_range(19))
            0: begin
               push(FUNC_SWEEP, 8'($urandom), 6'($urandom), 2'($urandom));
               n++;
            end
            1, 2, 3: begin
               push(FUNC_READ, 8'($urandom), 6'($urandom_range(63)), 2'($urandom));
               n++;
            end
            4: begin
               push(FUNC_BYTE, 8'($urandom), 6'($urandom), 2'($urandom));
               n++;
            end
            5: begin
               push(FUNC_NOP, 8'($urandom), 6'($urandom), 2'($urandom));
               n++;
            end
            default: begin
               n -= pending_items.size();
               push_sentence(prn_span);
               n += pending_items.size();
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (2 * (8 * DEPTH + 10)) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_MAX_AGE) max_age = value;
      else if (idx == REG_SNR_THR) snr_limit = value[9:0];
      else min_len = value[6:0];
      @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int prn_span,
                            input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      push_random(count, prn_span);
      wait_drained();
   endtask

   initial begin
      string s;
      max_age = MAX_AGE_RESET;
      snr_limit = SNR_THR_RESET;
      min_len = MIN_LEN_RESET;
      sat_count = 0;
      foreach (view_count[k]) view_count[k] = '0;
      foreach (tracked[k]) tracked[k] = 0;
      clear_line();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: text before any dollar, every talker, saturation, zero byte,
      // token cap, overlong line, short sentence, reads and two sweeps.
      push_text("GPGSV,1,1,04,07,45,120,33*");
      push(FUNC_BYTE, CH_LF, 0, 0);
      push_text("$GLGSV,2,1,9999,65,90,359,99999*00");
      push(FUNC_BYTE, CH_CR, 0, 2);
      push_text("$BDGSV,1,1,02,3,4,5,6,8,9");
      push(FUNC_BYTE, 8'h00, 0, 1);
      push(FUNC_BYTE, 8'hFF, 0, 1);
      push(FUNC_BYTE, CH_LF, 0, 1);
      s = "$GBGSV,1,1,20";
      for (int k = 0; k < 8; k++) s = {s, $sformatf(",%0d,1,2,3", 40 + k)};
      push_text(s);
      push(FUNC_BYTE, CH_CR, 0, 1);
      s = "$XXGSV,1,1,01";
      for (int k = 0; k < 30; k++) s = {s, ",77,1,2,3"};
      push_text(s);
      push(FUNC_BYTE, CH_LF, 0, 3);
      push_text("$GPGSV,");
      push(FUNC_BYTE, CH_LF, 0, 0);
      for (int k = 0; k < 6; k++) push(FUNC_READ, 0, 6'(k), k[1:0]);
      push(FUNC_READ, 0, 6'd63, 0);
      push(FUNC_NOP, 8'hFF, 6'd63, 3);
      clock_ms = 32'hFFFF_FFF0;
      push(FUNC_SWEEP, 0, 0, 0);
      push(FUNC_SWEEP, 0, 0, 0);
      wait_drained();

      write_reg(REG_MAX_AGE, 16'd1500);
      write_reg(REG_SNR_THR, 16'd20);
      write_reg(REG_MIN_LEN, 16'd0);
      clock_ms = 32'hFFFF_F000;
      run_phase(200, 20, 0, 0);
      run_phase(200, 99, 55, 0);

      write_reg(REG_MAX_AGE, 16'hFFFF);
      write_reg(REG_SNR_THR, 16'd0);
      write_reg(REG_MIN_LEN, 16'd127);
      run_phase(100, 40, 0, 55);

      // Fill the table: many distinct satellites and no ageing.
      write_reg(REG_MIN_LEN, 16'd10);
      write_reg(REG_SNR_THR, 16'd999);
      run_phase(250, 999, 22, 22);

      // Long receiver hold while the sender keeps offering items.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fork
         begin
            hold_on <= 1'b1;
            repeat (400) @(posedge clock);
            hold_on <= 1'b0;
         end
      join_none
      push_random(60, 30);
      wait_drained();

      write_reg(REG_MAX_AGE, 16'd0);
      write_reg(REG_SNR_THR, 16'd15);
      run_phase(200, 30, 55, 55);
      write_reg(REG_MAX_AGE, 16'd5000);
      run_phase(250, 60, 0, 0);
      for (int k = 0; k < 4; k++) push(FUNC_SWEEP, 0, 0, 0);
      wait_drained();

      $display("covered %0d beats, %0d responses checked, %0d table reads hit",
               accepted, checked, reads_hit);
      $display("table held %0d entries at the end", sat_count);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/gsvst_pkg.sv
rtl/gsv_satellite_table_core.sv
tb/testbench.sv
